// ===== rtl/bwmv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bwmv_pkg
// Shared widths, register codes and record types of the bowtie wedge mask
// voxel unit.
// ----------------------------------------------------------------------------
package bwmv_pkg;

	localparam int POS_W     = 6;
	localparam int POS_CODES = 1 << POS_W;
	localparam int ADDR_W    = 18;
	localparam int TAN_W     = 32;
	localparam int FRAC_W    = 16;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAN_LOW      = 2'd0,
		REG_TAN_HIGH     = 2'd1,
		REG_EDGE_ENABLE  = 2'd2,
		REG_SHIFT_ENABLE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [TAN_W-1:0] tan_low;
		logic signed [TAN_W-1:0] tan_high;
		logic                    edge_en;
		logic                    shift_en;
	} cfg_t;

	typedef struct packed {
		logic              plain_value;
		logic [ADDR_W-1:0] plain_address;
		logic              shift_write;
		logic              shift_value;
		logic [ADDR_W-1:0] shift_address;
		logic              half_valid;
		logic [ADDR_W-1:0] half_address;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/bwmv_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bwmv_cfg_if
// Register write channel: index and data under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bwmv_cfg_if import bwmv_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [TAN_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/bwmv_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bwmv_in_if
// Voxel coordinate channel: one centred coordinate per request.
// ----------------------------------------------------------------------------
interface bwmv_in_if import bwmv_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;

	modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/bwmv_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bwmv_out_if
// Mask result channel: plain, shifted and half-volume value and addresses.
// ----------------------------------------------------------------------------
interface bwmv_out_if import bwmv_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              plain_value;
	logic [ADDR_W-1:0] plain_address;
	logic              shift_write;
	logic              shift_value;
	logic [ADDR_W-1:0] shift_address;
	logic              half_valid;
	logic [ADDR_W-1:0] half_address;

	modport source (
		output valid, output plain_value, output plain_address, output shift_write,
		output shift_value, output shift_address, output half_valid,
		output half_address, input ready
	);
	modport sink (
		input valid, input plain_value, input plain_address, input shift_write,
		input shift_value, input shift_address, input half_valid,
		input half_address, output ready
	);
endinterface
`default_nettype wire

// ===== rtl/bowtie_wedge_mask_voxel_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bowtie_wedge_mask_voxel_unit
// Missing-wedge bowtie mask for one voxel per request: plain mask value and
// address, fft-shifted value and address, and the half-volume address.
// ----------------------------------------------------------------------------
// Pipeline: a request passes the wrap, mult and resolve stage registers in turn.
// Throughput: one voxel per cycle; the three stages stall together only when
// the output is held and every stage behind it is full.
// Reset: clears the stage valid bits and loads the register reset values;
// the unit is ready for requests as soon as reset is released.
module bowtie_wedge_mask_voxel_unit import bwmv_pkg::*; #(
	parameter int CUBE_SIDE = 64
) (
	input  wire          clk,
	input  wire          arst_n,
	bwmv_cfg_if.sink     cfg,
	bwmv_in_if.sink      pos_in,
	bwmv_out_if.source   mask_out
);

	localparam int IW = $clog2(CUBE_SIDE);
	localparam int PW = IW + 33;
	localparam int SQW = 2 * IW;

	cfg_t cfg_q;

	logic valid_s1, valid_s2, valid_s3;
	logic en1, en2, en3;

	logic [IW-1:0] ix_s1, iy_s1, iz_s1, sx_s1, sy_s1, sz_s1;

	logic [IW-1:0]        ix_s2, sx_s2;
	logic                 z_zero_s2;
	logic signed [IW:0]   num_s2;
	logic signed [PW-1:0] prod_lo_s2, prod_hi_s2;
	logic [SQW-1:0]       sq_x_s2, sq_y_s2, sq_z_s2;
	logic [ADDR_W-1:0]    row_s2, slab_s2, srow_s2, sslab_s2, hrow_s2, hslab_s2;

	result_t res_s3;

	// A stage moves on when it is empty or the stage after it moves on.
	assign en3 = !valid_s3 || mask_out.ready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign pos_in.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1)
				valid_s1 <= pos_in.valid;
			if (en2)
				valid_s2 <= valid_s1;
			if (en3)
				valid_s3 <= valid_s2;
		end
	end

	bwmv_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	bwmv_wrap_stage #(.CUBE_SIDE(CUBE_SIDE)) u_wrap (
		.clk   (clk),
		.load  (en1 && pos_in.valid),
		.pos_x (pos_in.pos_x),
		.pos_y (pos_in.pos_y),
		.pos_z (pos_in.pos_z),
		.ix_s1 (ix_s1),
		.iy_s1 (iy_s1),
		.iz_s1 (iz_s1),
		.sx_s1 (sx_s1),
		.sy_s1 (sy_s1),
		.sz_s1 (sz_s1)
	);

	bwmv_mult_stage #(.CUBE_SIDE(CUBE_SIDE)) u_mult (
		.clk        (clk),
		.load       (en2 && valid_s1),
		.cfg        (cfg_q),
		.ix_s1      (ix_s1),
		.iy_s1      (iy_s1),
		.iz_s1      (iz_s1),
		.sx_s1      (sx_s1),
		.sy_s1      (sy_s1),
		.sz_s1      (sz_s1),
		.ix_s2      (ix_s2),
		.sx_s2      (sx_s2),
		.z_zero_s2  (z_zero_s2),
		.num_s2     (num_s2),
		.prod_lo_s2 (prod_lo_s2),
		.prod_hi_s2 (prod_hi_s2),
		.sq_x_s2    (sq_x_s2),
		.sq_y_s2    (sq_y_s2),
		.sq_z_s2    (sq_z_s2),
		.row_s2     (row_s2),
		.slab_s2    (slab_s2),
		.srow_s2    (srow_s2),
		.sslab_s2   (sslab_s2),
		.hrow_s2    (hrow_s2),
		.hslab_s2   (hslab_s2)
	);

	bwmv_resolve_stage #(.CUBE_SIDE(CUBE_SIDE)) u_resolve (
		.clk        (clk),
		.load       (en3 && valid_s2),
		.cfg        (cfg_q),
		.ix_s2      (ix_s2),
		.sx_s2      (sx_s2),
		.z_zero_s2  (z_zero_s2),
		.num_s2     (num_s2),
		.prod_lo_s2 (prod_lo_s2),
		.prod_hi_s2 (prod_hi_s2),
		.sq_x_s2    (sq_x_s2),
		.sq_y_s2    (sq_y_s2),
		.sq_z_s2    (sq_z_s2),
		.row_s2     (row_s2),
		.slab_s2    (slab_s2),
		.srow_s2    (srow_s2),
		.sslab_s2   (sslab_s2),
		.hrow_s2    (hrow_s2),
		.hslab_s2   (hslab_s2),
		.res_s3     (res_s3)
	);

	assign mask_out.valid         = valid_s3;
	assign mask_out.plain_value   = res_s3.plain_value;
	assign mask_out.plain_address = res_s3.plain_address;
	assign mask_out.shift_write   = res_s3.shift_write;
	assign mask_out.shift_value   = res_s3.shift_value;
	assign mask_out.shift_address = res_s3.shift_address;
	assign mask_out.half_valid    = res_s3.half_valid;
	assign mask_out.half_address  = res_s3.half_address;

endmodule
`default_nettype wire

// ===== rtl/bwmv_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bwmv_cfg_regs
// Configuration register file: wedge tangents and the edge and shift enables.
// ----------------------------------------------------------------------------
module bwmv_cfg_regs import bwmv_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	bwmv_cfg_if.sink     cfg,
	output cfg_t         cfg_q
);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tan_low  <= '0;
			cfg_q.tan_high <= '0;
			cfg_q.edge_en  <= 1'b0;
			cfg_q.shift_en <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_TAN_LOW:      cfg_q.tan_low  <= $signed(cfg.data);
				REG_TAN_HIGH:     cfg_q.tan_high <= $signed(cfg.data);
				REG_EDGE_ENABLE:  cfg_q.edge_en  <= cfg.data[0];
				REG_SHIFT_ENABLE: cfg_q.shift_en <= cfg.data[0];
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bwmv_wrap_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bwmv_wrap_stage
// First stage: wraps each centred coordinate into a cube index and its
// circularly shifted index, both through small constant tables.
// ----------------------------------------------------------------------------
module bwmv_wrap_stage import bwmv_pkg::*; #(
	parameter int CUBE_SIDE = 64
) (
	input  wire                          clk,
	input  wire                          load,
	input  wire  signed [POS_W-1:0]      pos_x,
	input  wire  signed [POS_W-1:0]      pos_y,
	input  wire  signed [POS_W-1:0]      pos_z,
	output logic [$clog2(CUBE_SIDE)-1:0] ix_s1,
	output logic [$clog2(CUBE_SIDE)-1:0] iy_s1,
	output logic [$clog2(CUBE_SIDE)-1:0] iz_s1,
	output logic [$clog2(CUBE_SIDE)-1:0] sx_s1,
	output logic [$clog2(CUBE_SIDE)-1:0] sy_s1,
	output logic [$clog2(CUBE_SIDE)-1:0] sz_s1
);

	localparam int IW        = $clog2(CUBE_SIDE);
	localparam int HALF_SIDE = CUBE_SIDE / 2;

	// Index of a coordinate code, wrapped into the cube.
	function automatic int wrap_code(input int code);
		int c;
		int t;
		c = (code >= POS_CODES / 2) ? code - POS_CODES : code;
		t = (c + HALF_SIDE) % CUBE_SIDE;
		if (t < 0)
			t = t + CUBE_SIDE;
		return t;
	endfunction

	logic [IW-1:0] wrap_lut  [POS_CODES];
	logic [IW-1:0] shift_lut [POS_CODES];

	for (genvar g = 0; g < POS_CODES; g++) begin : g_lut
		assign wrap_lut[g]  = IW'(wrap_code(g));
		assign shift_lut[g] = IW'((wrap_code(g) + HALF_SIDE) % CUBE_SIDE);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ix_s1 <= wrap_lut[$unsigned(pos_x)];
			iy_s1 <= wrap_lut[$unsigned(pos_y)];
			iz_s1 <= wrap_lut[$unsigned(pos_z)];
			sx_s1 <= shift_lut[$unsigned(pos_x)];
			sy_s1 <= shift_lut[$unsigned(pos_y)];
			sz_s1 <= shift_lut[$unsigned(pos_z)];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bwmv_mult_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bwmv_mult_stage
// Second stage: centres the indices, forms the tangent products, the squares
// for the edge radius and the address partial products.
// ----------------------------------------------------------------------------
module bwmv_mult_stage import bwmv_pkg::*; #(
	parameter int CUBE_SIDE = 64
) (
	input  wire                                   clk,
	input  wire                                   load,
	input  cfg_t                                  cfg,
	input  wire  [$clog2(CUBE_SIDE)-1:0]          ix_s1,
	input  wire  [$clog2(CUBE_SIDE)-1:0]          iy_s1,
	input  wire  [$clog2(CUBE_SIDE)-1:0]          iz_s1,
	input  wire  [$clog2(CUBE_SIDE)-1:0]          sx_s1,
	input  wire  [$clog2(CUBE_SIDE)-1:0]          sy_s1,
	input  wire  [$clog2(CUBE_SIDE)-1:0]          sz_s1,
	output logic [$clog2(CUBE_SIDE)-1:0]          ix_s2,
	output logic [$clog2(CUBE_SIDE)-1:0]          sx_s2,
	output logic                                  z_zero_s2,
	output logic signed [$clog2(CUBE_SIDE):0]     num_s2,
	output logic signed [$clog2(CUBE_SIDE)+32:0]  prod_lo_s2,
	output logic signed [$clog2(CUBE_SIDE)+32:0]  prod_hi_s2,
	output logic [2*$clog2(CUBE_SIDE)-1:0]        sq_x_s2,
	output logic [2*$clog2(CUBE_SIDE)-1:0]        sq_y_s2,
	output logic [2*$clog2(CUBE_SIDE)-1:0]        sq_z_s2,
	output logic [ADDR_W-1:0]                     row_s2,
	output logic [ADDR_W-1:0]                     slab_s2,
	output logic [ADDR_W-1:0]                     srow_s2,
	output logic [ADDR_W-1:0]                     sslab_s2,
	output logic [ADDR_W-1:0]                     hrow_s2,
	output logic [ADDR_W-1:0]                     hslab_s2
);

	localparam int IW         = $clog2(CUBE_SIDE);
	localparam int CW         = IW + 1;
	localparam int PW         = IW + 33;
	localparam int SQW        = 2 * IW;
	localparam int HALF_SIDE  = CUBE_SIDE / 2;
	localparam int HALF_W     = HALF_SIDE + 1;
	localparam int SIDE_SQ    = CUBE_SIDE * CUBE_SIDE;
	localparam int HALF_SLAB  = HALF_W * CUBE_SIDE;
	localparam logic signed [CW-1:0] HALF_C = CW'(HALF_SIDE);

	logic signed [CW-1:0]   x, y, z;
	logic signed [CW-1:0]   num, den_full;
	logic [IW-1:0]          den;
	logic signed [CW-1:0]   den_s;
	logic signed [2*CW-1:0] x_sq, y_sq, z_sq;
	logic                   z_neg;

	always_comb begin
		x        = $signed({1'b0, ix_s1}) - HALF_C;
		y        = $signed({1'b0, iy_s1}) - HALF_C;
		z        = $signed({1'b0, iz_s1}) - HALF_C;
		z_neg    = z[CW-1];
		// Fold the sign of z into x so the tangent test runs on a positive divisor.
		num      = z_neg ? -x : x;
		den_full = z_neg ? -z : z;
		den      = den_full[IW-1:0];
		den_s    = $signed({1'b0, den});
		x_sq     = (2 * CW)'(x) * (2 * CW)'(x);
		y_sq     = (2 * CW)'(y) * (2 * CW)'(y);
		z_sq     = (2 * CW)'(z) * (2 * CW)'(z);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ix_s2      <= ix_s1;
			sx_s2      <= sx_s1;
			z_zero_s2  <= (z == '0);
			num_s2     <= num;
			prod_lo_s2 <= PW'(cfg.tan_low) * PW'(den_s);
			prod_hi_s2 <= PW'(cfg.tan_high) * PW'(den_s);
			sq_x_s2    <= x_sq[SQW-1:0];
			sq_y_s2    <= y_sq[SQW-1:0];
			sq_z_s2    <= z_sq[SQW-1:0];
			row_s2     <= ADDR_W'(iy_s1 * CUBE_SIDE);
			slab_s2    <= ADDR_W'(iz_s1 * SIDE_SQ);
			srow_s2    <= ADDR_W'(sy_s1 * CUBE_SIDE);
			sslab_s2   <= ADDR_W'(sz_s1 * SIDE_SQ);
			hrow_s2    <= ADDR_W'(sy_s1 * HALF_W);
			hslab_s2   <= ADDR_W'(sz_s1 * HALF_SLAB);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bwmv_resolve_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bwmv_resolve_stage
// Third stage: wedge and edge comparisons, address sums and output gating
// into the result register.
// ----------------------------------------------------------------------------
module bwmv_resolve_stage import bwmv_pkg::*; #(
	parameter int CUBE_SIDE = 64
) (
	input  wire                                  clk,
	input  wire                                  load,
	input  cfg_t                                 cfg,
	input  wire  [$clog2(CUBE_SIDE)-1:0]         ix_s2,
	input  wire  [$clog2(CUBE_SIDE)-1:0]         sx_s2,
	input  wire                                  z_zero_s2,
	input  wire  signed [$clog2(CUBE_SIDE):0]    num_s2,
	input  wire  signed [$clog2(CUBE_SIDE)+32:0] prod_lo_s2,
	input  wire  signed [$clog2(CUBE_SIDE)+32:0] prod_hi_s2,
	input  wire  [2*$clog2(CUBE_SIDE)-1:0]       sq_x_s2,
	input  wire  [2*$clog2(CUBE_SIDE)-1:0]       sq_y_s2,
	input  wire  [2*$clog2(CUBE_SIDE)-1:0]       sq_z_s2,
	input  wire  [ADDR_W-1:0]                    row_s2,
	input  wire  [ADDR_W-1:0]                    slab_s2,
	input  wire  [ADDR_W-1:0]                    srow_s2,
	input  wire  [ADDR_W-1:0]                    sslab_s2,
	input  wire  [ADDR_W-1:0]                    hrow_s2,
	input  wire  [ADDR_W-1:0]                    hslab_s2,
	output result_t                              res_s3
);

	localparam int IW       = $clog2(CUBE_SIDE);
	localparam int CW       = IW + 1;
	localparam int PW       = IW + 33;
	localparam int SQW      = 2 * IW;
	localparam int HALF_W   = CUBE_SIDE / 2 + 1;
	localparam int EDGE_R   = (CUBE_SIDE - 1) / 2;
	localparam logic [SQW-1:0] EDGE_R_SQ = SQW'(EDGE_R * EDGE_R);
	localparam logic [IW:0]    HALF_W_C  = (IW + 1)'(HALF_W);

	logic signed [PW-1:0] lhs;
	logic [SQW-1:0]       radius_sq;
	logic                 wedge, beyond_edge, in_half;
	logic [ADDR_W-1:0]    sx_ext;
	result_t              res;

	always_comb begin
		lhs         = {{(PW - CW - FRAC_W){num_s2[CW-1]}}, num_s2, {FRAC_W{1'b0}}};
		wedge       = !z_zero_s2 && (prod_lo_s2 < lhs) && (lhs < prod_hi_s2);
		radius_sq   = sq_x_s2 + sq_y_s2 + sq_z_s2;
		beyond_edge = cfg.edge_en && (radius_sq >= EDGE_R_SQ);
		in_half     = cfg.shift_en && ({1'b0, sx_s2} < HALF_W_C);
		sx_ext      = ADDR_W'(sx_s2);

		res.plain_value   = !wedge;
		res.plain_address = ADDR_W'(ix_s2) + row_s2 + slab_s2;
		res.shift_write   = cfg.shift_en;
		res.shift_value   = cfg.shift_en && !(wedge || beyond_edge);
		res.shift_address = cfg.shift_en ? (sx_ext + srow_s2 + sslab_s2) : '0;
		res.half_valid    = in_half;
		res.half_address  = in_half ? (sx_ext + hrow_s2 + hslab_s2) : '0;
	end

	always_ff @(posedge clk) begin
		if (load)
			res_s3 <= res;
	end

endmodule
`default_nettype wire
